### sv/echo_distance_averager_defines.svh
// Assertion macros for the echo distance averager.
// Used by the top level; expects clk and rst_n in scope.
`ifndef ECHO_DISTANCE_AVERAGER_DEFINES_SVH
`define ECHO_DISTANCE_AVERAGER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent
`define EDA_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define EDA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/eda_pkg.sv
// Shared types and constants for the echo distance averager.
// No dependencies; imported by every module of the block.
package eda_pkg;

    localparam int ECHO_W     = 16;
    localparam int DIST_W     = 10;
    localparam int TPC_W      = 8;
    localparam int DIV_W      = 16;
    localparam int DVSR_W     = 8;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 10;
    localparam int WINDOW_DEF = 5;

    localparam logic [TPC_W-1:0]  TPC_RESET   = 8'd117;
    localparam logic [DIST_W-1:0] LIMIT_RESET = 10'd400;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TICKS_PER_CM   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_RANGE_LIMIT_CM = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RAW_START,
        ST_RAW_WAIT,
        ST_INSERT,
        ST_SUM,
        ST_AVG_START,
        ST_AVG_WAIT,
        ST_HOLD
    } eda_state_t;

    typedef struct packed {
        logic              start;
        logic [DIV_W-1:0]  dividend;
        logic [DVSR_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quotient;
    } div_rsp_t;

endpackage

### sv/eda_cell.sv
// One sample cell of the averaging window chain.
// Depends on eda_pkg for the sample width.
module eda_cell
    import eda_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              shift_en,
    input  logic [DIST_W-1:0] d_in,
    output logic [DIST_W-1:0] d_out
);

    logic [DIST_W-1:0] sample_reg;
    logic [DIST_W-1:0] sample_next;

    // Take the neighbor's sample on a shift, otherwise hold
    always_comb
    begin
        sample_next = shift_en ? d_in : sample_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_reg <= '0;
        end
        else
        begin
            sample_reg <= sample_next;
        end
    end

    assign d_out = sample_reg;

endmodule

### sv/eda_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on eda_pkg for widths and the request/response structs.
module eda_div
    import eda_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    localparam int CNT_W = $clog2(DIV_W + 1);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [DIV_W-1:0]  quo_reg, quo_next;
    logic [DVSR_W-1:0] rem_reg, rem_next;
    logic [DVSR_W-1:0] dvsr_reg, dvsr_next;
    logic [DVSR_W:0]   trial;
    logic [DVSR_W:0]   diff;
    logic              fits;

    // Shift one dividend bit into the remainder and try the subtract
    always_comb
    begin
        trial = {rem_reg, quo_reg[DIV_W-1]};
        fits  = (trial >= {1'b0, dvsr_reg});
        diff  = trial - {1'b0, dvsr_reg};

        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvsr_next = dvsr_reg;

        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(DIV_W);
            quo_next  = req.dividend;
            rem_next  = '0;
            dvsr_next = req.divisor;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? diff[DVSR_W-1:0] : trial[DVSR_W-1:0];
            quo_next = {quo_reg[DIV_W-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        quo_reg  <= quo_next;
        rem_reg  <= rem_next;
        dvsr_reg <= dvsr_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

### sv/echo_distance_averager.sv
// Top level of the echo distance averager: control, config and window chain.
// Depends on eda_pkg, eda_cell, eda_div and echo_distance_averager_defines.svh.
//
//  channel | valid     | ready     | payload
//  --------+-----------+-----------+------------------------------
//  in      | in_valid  | in_ready  | echo_ticks
//  out     | out_valid | out_ready | average_cm, raw_cm
//  cfg     | cfg_valid | cfg_ready | cfg_index, cfg_data
//
// A word passes through the states RAW_START and RAW_WAIT (a pass of the shared
// 16-step divider for the distance), INSERT, SUM (a rotation of the ring that
// accumulates every cell), AVG_START and AVG_WAIT (a second divider pass for
// the mean) and HOLD, which loads the output register. The input reopens the
// cycle after the load, so the block takes no new word before the last is through.
// Reset clears the window, the fill count and the output valid flag, and loads 117/400.
// An unread result holds in the output register; the next word is taken
// meanwhile, and its result waits until the output register frees.
`include "echo_distance_averager_defines.svh"

module echo_distance_averager
    import eda_pkg::*;
#(
    parameter int WINDOW = WINDOW_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [ECHO_W-1:0]     echo_ticks,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [DIST_W-1:0]     average_cm,
    output logic [DIST_W-1:0]     raw_cm,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int CNT_W = $clog2(WINDOW + 1);
    localparam int SUM_W = $clog2(WINDOW * ((1 << DIST_W) - 1) + 1);

    eda_state_t        state_reg, state_next;
    logic [ECHO_W-1:0] echo_reg, echo_next;
    logic [TPC_W-1:0]  tpc_reg, tpc_next;
    logic [DIST_W-1:0] limit_reg, limit_next;
    logic [DIST_W-1:0] raw_reg, raw_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  rot_reg, rot_next;
    logic [SUM_W-1:0]  sum_reg, sum_next;
    logic [DIST_W-1:0] avg_out_reg, avg_out_next;
    logic [DIST_W-1:0] raw_out_reg, raw_out_next;
    logic              out_valid_reg, out_valid_next;
    logic              shift_en;
    logic              insert;
    logic              out_free;
    div_req_t          div_req;
    div_rsp_t          div_rsp;
    logic [DIST_W-1:0] cell_q [WINDOW];

    // Window chain: insert drops the oldest sample, rotate cycles the ring
    for (genvar i = 0; i < WINDOW; i++)
    begin : g_cell
        logic [DIST_W-1:0] cell_d;
        if (i == 0)
        begin : g_head
            assign cell_d = insert ? raw_reg : cell_q[WINDOW-1];
        end
        else
        begin : g_body
            assign cell_d = cell_q[i-1];
        end
        eda_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .shift_en (shift_en),
            .d_in     (cell_d),
            .d_out    (cell_q[i])
        );
    end

    eda_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign out_free = !out_valid_reg || out_ready;

    // Next state and datapath control
    always_comb
    begin
        state_next     = state_reg;
        echo_next      = echo_reg;
        tpc_next       = tpc_reg;
        limit_next     = limit_reg;
        raw_next       = raw_reg;
        count_next     = count_reg;
        rot_next       = rot_reg;
        sum_next       = sum_reg;
        avg_out_next   = avg_out_reg;
        raw_out_next   = raw_out_reg;
        out_valid_next = out_valid_reg;
        shift_en       = 1'b0;
        insert         = 1'b0;
        div_req        = '0;
        in_ready       = (state_reg == ST_IDLE);

        // Drop the output word once taken
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        // Configuration writes
        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_TICKS_PER_CM:   tpc_next   = cfg_data[TPC_W-1:0];
                CFG_RANGE_LIMIT_CM: limit_next = cfg_data[DIST_W-1:0];
                default:            ;
            endcase
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    echo_next  = echo_ticks;
                    state_next = ST_RAW_START;
                end
            end
            ST_RAW_START:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = DIV_W'(echo_reg);
                div_req.divisor  = DVSR_W'(tpc_reg);
                state_next       = ST_RAW_WAIT;
            end
            ST_RAW_WAIT:
            begin
                if (div_rsp.done)
                begin
                    raw_next = (div_rsp.quotient > DIV_W'(limit_reg)) ?
                               '0 : div_rsp.quotient[DIST_W-1:0];
                    state_next = ST_INSERT;
                end
            end
            ST_INSERT:
            begin
                shift_en = 1'b1;
                insert   = 1'b1;
                if (count_reg != CNT_W'(WINDOW))
                begin
                    count_next = count_reg + 1'b1;
                end
                rot_next   = '0;
                sum_next   = '0;
                state_next = ST_SUM;
            end
            ST_SUM:
            begin
                // Accumulate the tail cell and advance the ring
                shift_en = 1'b1;
                sum_next = sum_reg + SUM_W'(cell_q[WINDOW-1]);
                rot_next = rot_reg + 1'b1;
                if (rot_reg == CNT_W'(WINDOW - 1))
                begin
                    state_next = ST_AVG_START;
                end
            end
            ST_AVG_START:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = DIV_W'(sum_reg);
                div_req.divisor  = DVSR_W'(count_reg);
                state_next       = ST_AVG_WAIT;
            end
            ST_AVG_WAIT:
            begin
                if (div_rsp.done)
                begin
                    state_next = ST_HOLD;
                end
            end
            ST_HOLD:
            begin
                if (out_free)
                begin
                    avg_out_next   = div_rsp.quotient[DIST_W-1:0];
                    raw_out_next   = raw_reg;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            tpc_reg       <= TPC_RESET;
            limit_reg     <= LIMIT_RESET;
            count_reg     <= '0;
            rot_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            tpc_reg       <= tpc_next;
            limit_reg     <= limit_next;
            count_reg     <= count_next;
            rot_reg       <= rot_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        echo_reg    <= echo_next;
        raw_reg     <= raw_next;
        sum_reg     <= sum_next;
        avg_out_reg <= avg_out_next;
        raw_out_reg <= raw_out_next;
    end

    assign cfg_ready  = 1'b1;
    assign out_valid  = out_valid_reg;
    assign average_cm = avg_out_reg;
    assign raw_cm     = raw_out_reg;

    // Checks on control sequencing
    `EDA_ASSERT_SAME(a_avg_divisor_nonzero, state_reg == ST_AVG_START,
        count_reg != '0, "mean divisor is zero")
    `EDA_ASSERT_SAME(a_div_done_expected, div_rsp.done,
        state_reg == ST_RAW_WAIT || state_reg == ST_AVG_WAIT,
        "divider finished outside a wait state")
    `EDA_ASSERT_SAME(a_out_from_hold, $rose(out_valid_reg),
        $past(state_reg == ST_HOLD), "output word loaded outside hold")
    `EDA_ASSERT_NEXT(a_sum_ends, state_reg == ST_SUM && rot_reg == CNT_W'(WINDOW - 1),
        state_reg == ST_AVG_START, "ring rotation overran")

endmodule

### tb/sv/tb.sv
`timescale 1ns / 100ps
// Testbench for echo_distance_averager: echo widths in, distance and window mean out.
// Depends on eda_pkg and the block's RTL; checks each output word against its own predictor.
module tb;
    import eda_pkg::*;

    localparam int WIN         = WINDOW_DEF;
    localparam int SETTLE      = 60;
    localparam int LONG_HOLD   = 600;
    localparam int STALL_LIMIT = 5000;
    localparam int PHASES      = 10;
    localparam int PHASE_WORDS = 115;

    typedef struct {
        logic [DIST_W-1:0] avg;
        logic [DIST_W-1:0] raw;
    } reading_t;

    logic                  clk        = 1'b0;
    logic                  rst_n      = 1'b0;
    logic                  in_valid   = 1'b0;
    logic                  in_ready;
    logic [ECHO_W-1:0]     echo_ticks = '0;
    logic                  out_valid;
    logic                  out_ready  = 1'b0;
    logic [DIST_W-1:0]     average_cm;
    logic [DIST_W-1:0]     raw_cm;
    logic                  cfg_valid  = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index  = CFG_TICKS_PER_CM;
    logic [CFG_DATA_W-1:0] cfg_data   = '0;

    // Predictor copy of the registers and the sample ring
    logic [TPC_W-1:0]  model_tpc    = TPC_RESET;
    logic [DIST_W-1:0] model_limit  = LIMIT_RESET;
    logic [DIST_W-1:0] dist_ring [WIN] = '{default: '0};
    int                ring_slot    = 0;
    logic              ring_wrapped = 1'b0;

    logic [ECHO_W-1:0] echo_backlog[$];
    reading_t          expected_readings[$];
    int                mismatch_count = 0;
    int                words_queued   = 0;
    int                words_checked  = 0;
    int                idle_pct       = 0;
    int                hold_requests  = 0;
    int                holds_served   = 0;
    int                send_gap       = 0;
    int                recv_stall     = 0;
    int                quiet_cycles   = 0;
    logic              next_valid;
    reading_t          want;

    echo_distance_averager #(.WINDOW(WIN)) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .echo_ticks (echo_ticks),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .average_cm (average_cm),
        .raw_cm     (raw_cm),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    always #5 clk = ~clk;

    // Convert an echo width to centimetres; out of range or no echo reads as zero
    function automatic logic [DIST_W-1:0] echo_to_cm(input logic [ECHO_W-1:0] ticks);
        logic [ECHO_W-1:0] quo;
        if (ticks == '0)
            return '0;
        // a zero divisor saturates the quotient
        quo = (model_tpc == '0) ? '1 : ticks / model_tpc;
        if (quo > model_limit)
            return '0;
        return quo[DIST_W-1:0];
    endfunction

    // Store one distance in the ring and form the truncated mean of the filled slots
    function automatic reading_t log_echo(input logic [ECHO_W-1:0] ticks);
        reading_t r;
        int       count;
        int       total = 0;
        r.raw = echo_to_cm(ticks);
        dist_ring[ring_slot] = r.raw;
        ring_slot++;
        if (ring_slot == WIN)
        begin
            ring_slot = 0;
            ring_wrapped = 1'b1;
        end
        count = ring_wrapped ? WIN : ring_slot;
        for (int i = 0; i < count; i++)
            total += dist_ring[i];
        r.avg = DIST_W'(total / count);
        return r;
    endfunction

    function automatic logic [ECHO_W-1:0] clip_echo(input int v);
        if (v < 0)
            return '0;
        if (v > 65535)
            return '1;
        return ECHO_W'(v);
    endfunction

    // Random echo width: mostly in range, some near the range edge, some wild
    function automatic logic [ECHO_W-1:0] pick_echo();
        int tpc = model_tpc;
        int edge_ticks = model_tpc * model_limit;
        case ($urandom_range(9))
            0:       return '0;
            1, 2:    return ECHO_W'($urandom_range(16'hFFFF));
            3, 4:    return clip_echo(edge_ticks - tpc + $urandom_range(2 * tpc + 1));
            default: return clip_echo($urandom_range(tpc * (model_limit + 1)));
        endcase
    endfunction

    task automatic queue_echo(input logic [ECHO_W-1:0] ticks);
        echo_backlog.push_back(ticks);
        words_queued++;
    endtask

    // Write one register; leaves the config channel quiet after the handshake
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        if (idx == CFG_TICKS_PER_CM)
            model_tpc = val[TPC_W-1:0];
        else
            model_limit = val;
        @(posedge clk);
    endtask

    task automatic set_regs(input logic [TPC_W-1:0] tpc, input logic [DIST_W-1:0] limit);
        if ($urandom_range(1))
        begin
            write_reg(CFG_TICKS_PER_CM, CFG_DATA_W'(tpc));
            write_reg(CFG_RANGE_LIMIT_CM, limit);
        end
        else
        begin
            write_reg(CFG_RANGE_LIMIT_CM, limit);
            write_reg(CFG_TICKS_PER_CM, CFG_DATA_W'(tpc));
        end
    endtask

    // Hold off until every queued word has come back, then let the block settle
    task automatic drain();
        while (words_checked != words_queued)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // Feed echo words from the backlog, with random gaps between words
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid   <= 1'b0;
            echo_ticks <= '0;
            send_gap = 0;
        end
        else
        begin
            next_valid = in_valid;
            if (in_valid && in_ready)
            begin
                expected_readings.push_back(log_echo(echo_ticks));
                next_valid = 1'b0;
                if (idle_pct > 0 && $urandom_range(99) < idle_pct)
                    send_gap = $urandom_range(1, 13);
            end
            if (!next_valid)
            begin
                if (send_gap > 0)
                    send_gap--;
                else if (echo_backlog.size() > 0)
                begin
                    echo_ticks <= echo_backlog.pop_front();
                    next_valid = 1'b1;
                end
            end
            in_valid <= next_valid;
        end
    end

    // Take result words, compare against the oldest prediction, stall at random
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            recv_stall = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                words_checked++;
                if (expected_readings.size() == 0)
                begin
                    $display("%0t: unexpected word average_cm=%0d raw_cm=%0d",
                             $time, average_cm, raw_cm);
                    mismatch_count++;
                end
                else
                begin
                    want = expected_readings.pop_front();
                    if (average_cm !== want.avg)
                    begin
                        $display("%0t: average_cm expected %0d got %0d",
                                 $time, want.avg, average_cm);
                        mismatch_count++;
                    end
                    if (raw_cm !== want.raw)
                    begin
                        $display("%0t: raw_cm expected %0d got %0d",
                                 $time, want.raw, raw_cm);
                        mismatch_count++;
                    end
                end
            end
            if (recv_stall > 0)
                recv_stall--;
            else if (holds_served != hold_requests)
            begin
                // long hold-off so the block backs up and drops in_ready
                holds_served = hold_requests;
                recv_stall = LONG_HOLD;
            end
            else if (idle_pct > 0 && $urandom_range(7) == 0)
                recv_stall = $urandom_range(1, 13);
            out_ready <= (recv_stall == 0);
        end
    end

    // End the run when no channel has moved a word for too long
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)
            || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    initial
    begin
        logic [TPC_W-1:0]  tpc;
        logic [DIST_W-1:0] limit;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset registers: no echo, overflow, limit exactly kept, just above, tiny widths
        queue_echo(16'd0);
        queue_echo(16'd65535);
        queue_echo(16'd46800);
        queue_echo(16'd46916);
        queue_echo(16'd46917);
        queue_echo(16'd1);
        queue_echo(16'd116);
        queue_echo(16'd117);
        queue_echo(16'd234);
        drain();

        // Unit divisor, widest limit: largest distance and largest mean
        set_regs(8'd1, 10'd1023);
        queue_echo(16'd1024);
        queue_echo(16'd65535);
        repeat (5) queue_echo(16'd1023);
        drain();

        // Zero divisor saturates and always reads as out of range
        set_regs(8'd0, 10'd1023);
        queue_echo(16'd1);
        queue_echo(16'd65535);
        queue_echo(16'd0);
        drain();

        // Zero limit: only a zero quotient survives
        set_regs(8'd255, 10'd0);
        queue_echo(16'd254);
        queue_echo(16'd255);
        queue_echo(16'd65535);
        drain();

        // Random phases, each under its own register setting
        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0: begin tpc = 8'd64;  limit = 10'd1023; end
                1: begin tpc = 8'd255; limit = 10'd0;    end
                2: begin tpc = 8'd0;   limit = 10'($urandom_range(1023)); end
                default:
                begin
                    case ($urandom_range(5))
                        0:       tpc = 8'd1;
                        1:       tpc = 8'd255;
                        default: tpc = 8'($urandom_range(64, 255));
                    endcase
                    case ($urandom_range(5))
                        0:       limit = 10'd0;
                        1:       limit = 10'd1023;
                        default: limit = 10'($urandom_range(1023));
                    endcase
                end
            endcase
            set_regs(tpc, limit);
            // no idling in one middle phase and in the closing phase
            if (p == 4 || p == PHASES - 1)
                idle_pct = 0;
            else
                idle_pct = $urandom_range(10, 60);
            if (p == 3)
                hold_requests++;
            for (int i = 0; i < PHASE_WORDS; i++)
                queue_echo(pick_echo());
            drain();
        end

        if (mismatch_count == 0 && expected_readings.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

### filelist.f
+incdir+sv
sv/eda_pkg.sv
sv/eda_cell.sv
sv/eda_div.sv
sv/echo_distance_averager.sv
tb/sv/tb.sv
